// ----- design/bbp_pkg.sv -----
// Shared types, codes and defaults for the bimodal branch predictor with target buffer.
package bbp_pkg;

  // Default table sizes
  localparam int HIST_ENTRIES_DEF = 512;
  localparam int TGT_ENTRIES_DEF  = 512;

  // Width of a branch address
  localparam int PC_W = 64;

  // Function codes carried on in_tuser
  localparam logic [1:0] FUNC_PREDICT = 2'd0;
  localparam logic [1:0] FUNC_UPDATE  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;

  // Two-bit counter values
  localparam logic [1:0] CNT_ZERO  = 2'd0;
  localparam logic [1:0] CNT_TAKEN = 2'd2;
  localparam logic [1:0] CNT_MAX   = 2'd3;

  // History table entry
  typedef struct packed {
    logic            valid;
    logic [PC_W-1:0] tag;
    logic [1:0]      cnt;
  } hist_ent_t;

  // Target buffer entry
  typedef struct packed {
    logic            valid;
    logic [PC_W-1:0] tag;
    logic [PC_W-1:0] addr;
  } tgt_ent_t;

endpackage

// ----- design/bbp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module bbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/bbp_index.sv -----
// Table index unit: branch address modulo the table depth.
module bbp_index import bbp_pkg::*; #(
  parameter int ENTRIES = HIST_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [PC_W-1:0]            pc,
  output logic [$clog2(ENTRIES)-1:0] idx,
  output logic                       done
);

  localparam int IW = $clog2(ENTRIES);
  localparam bit IS_POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);

  logic done_r;
  logic done_nxt;

  assign done = done_r;

  generate
    if (IS_POW2) begin : g_mask
      // Power-of-two depth: the index is the low address bits
      logic [IW-1:0] idx_r;

      always_ff @(posedge clk) begin
        if (start) begin
          idx_r <= pc[IW-1:0];
        end
      end

      always_comb begin
        done_nxt = done_r;
        if (start) begin
          done_nxt = 1'b1;
        end
      end

      assign idx = idx_r;
    end else begin : g_fold
      // Other depths: fold the 16-bit pc chunks by their residues, estimate the
      // quotient of the folded sum by a reciprocal, then correct by one subtract.
      // The value passes through the sum, quotient, remainder and index registers; done marks it ready.
      localparam int            FW    = 34;
      localparam logic [15:0]   R1    = 16'((64'd1 << 16) % 64'(ENTRIES));
      localparam logic [15:0]   R2    = 16'((64'd1 << 32) % 64'(ENTRIES));
      localparam logic [15:0]   R3    = 16'((64'd1 << 48) % 64'(ENTRIES));
      localparam logic [31:0]   RECIP = 32'((64'd1 << FW) / 64'(ENTRIES));

      logic [FW-1:0]  fold;
      logic [FW-1:0]  sum_r;
      logic [FW+31:0] qprod;
      logic [31:0]    quo_r;
      logic [FW-1:0]  diff;
      logic [IW:0]    rem_r;
      logic [IW-1:0]  idx_r;
      logic [2:0]     stg_r;
      logic [2:0]     stg_nxt;

      // Fold, quotient estimate and remainder
      always_comb begin
        fold  = FW'(pc[15:0]) + FW'(32'(pc[31:16]) * 32'(R1))
              + FW'(32'(pc[47:32]) * 32'(R2)) + FW'(32'(pc[63:48]) * 32'(R3));
        qprod = (FW+32)'(sum_r) * (FW+32)'(RECIP);
        diff  = sum_r - FW'(quo_r) * FW'(ENTRIES);
      end

      // Stage tracking
      always_comb begin
        stg_nxt  = {stg_r[1:0], start};
        done_nxt = done_r;
        if (start) begin
          done_nxt = 1'b0;
        end else if (stg_r[2]) begin
          done_nxt = 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_r <= '0;
        end else begin
          stg_r <= stg_nxt;
        end
      end

      // Remainder below twice the depth; one conditional subtract finishes it
      always_ff @(posedge clk) begin
        if (start) begin
          sum_r <= fold;
        end
        quo_r <= qprod[FW+31:FW];
        rem_r <= diff[IW:0];
        idx_r <= (rem_r >= (IW+1)'(ENTRIES)) ? IW'(rem_r - (IW+1)'(ENTRIES))
                                             : rem_r[IW-1:0];
      end

      assign idx = idx_r;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

endmodule

// ----- design/bimodal_branch_predictor_btb.sv -----
// Bimodal two-bit branch predictor with a branch target buffer (top level).
// Each input word carries a function on in_tuser: predict, update or clear. A predict returns
// one output word (taken flag and next pc); update and clear return none. Both tables are
// direct mapped, indexed by pc modulo their depth and tagged with the full pc, and live in
// single-port-read RAMs handled by read, modify and write back, one word at a time. A predict
// or update passes through accept, index, RAM read and write back; a predict waits in write
// back while the output register is full and out_tready is low. For a depth that is not a power
// of two the index unit first reduces the pc by fold, reciprocal quotient and subtract. After
// reset and after every clear the block sweeps every entry of both tables and holds in_tready
// low meanwhile. A finished prediction sits in an output register, so the next word is taken while it waits.
module bimodal_branch_predictor_btb import bbp_pkg::*; #(
  parameter int HIST_ENTRIES = HIST_ENTRIES_DEF,
  parameter int TGT_ENTRIES  = TGT_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [63:0] pc, [127:64] fallthru_pc, [128] actual_taken, [192:129] resolved_tgt, pad
  input  logic [199:0] in_tdata,
  // [1:0] func
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] predict_taken, [64:1] next_pc, pad
  output logic [71:0]  out_tdata
);

  localparam int HIW  = $clog2(HIST_ENTRIES);
  localparam int TIW  = $clog2(TGT_ENTRIES);
  localparam int MAXD = (HIST_ENTRIES > TGT_ENTRIES) ? HIST_ENTRIES : TGT_ENTRIES;
  localparam int CW   = $clog2(MAXD);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_INDEX = 5'b00100,
    ST_READ  = 5'b01000,
    ST_WRITE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] clr_cnt_r, clr_cnt_nxt;

  // Latched word
  logic [1:0]      func_r;
  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] dflt_r;
  logic            act_taken_r;
  logic [PC_W-1:0] act_tgt_r;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [71:0] out_data_r, out_data_nxt;

  logic in_acc;
  logic idx_start;
  logic [HIW-1:0] h_idx;
  logic [TIW-1:0] t_idx;
  logic h_done, t_done;

  // RAM ports
  logic           h_we, t_we, rd_en;
  logic [HIW-1:0] h_waddr;
  logic [TIW-1:0] t_waddr;
  hist_ent_t      h_wdata, h_rdata;
  tgt_ent_t       t_wdata, t_rdata;

  // Lookup and modify
  logic       h_hit, t_hit;
  logic [1:0] cnt_cur, cnt_new;
  logic       pred_taken;
  logic       can_push, leave_wr;
  logic       clr_h, clr_t;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign idx_start = in_acc && ((in_tuser == FUNC_PREDICT) || (in_tuser == FUNC_UPDATE));

  bbp_index #(.ENTRIES(HIST_ENTRIES)) u_hidx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (idx_start),
    .pc    (in_tdata[63:0]),
    .idx   (h_idx),
    .done  (h_done)
  );

  bbp_index #(.ENTRIES(TGT_ENTRIES)) u_tidx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (idx_start),
    .pc    (in_tdata[63:0]),
    .idx   (t_idx),
    .done  (t_done)
  );

  // Lookup on the read data
  always_comb begin
    h_hit      = h_rdata.valid && (h_rdata.tag == pc_r);
    t_hit      = t_rdata.valid && (t_rdata.tag == pc_r);
    cnt_cur    = h_hit ? h_rdata.cnt : CNT_ZERO;
    pred_taken = h_hit && (cnt_cur >= CNT_TAKEN) && t_hit;
    cnt_new    = cnt_cur;
    if (func_r == FUNC_UPDATE) begin
      if (act_taken_r) begin
        cnt_new = (cnt_cur == CNT_MAX) ? CNT_MAX : cnt_cur + 2'd1;
      end else begin
        cnt_new = (cnt_cur == CNT_ZERO) ? CNT_ZERO : cnt_cur - 2'd1;
      end
    end
  end

  assign can_push = !out_valid_r || out_tready;
  assign leave_wr = (func_r != FUNC_PREDICT) || can_push;

  // Sweep covers each table only up to its own depth
  assign clr_h = ({1'b0, clr_cnt_r} < (CW+1)'(HIST_ENTRIES));
  assign clr_t = ({1'b0, clr_cnt_r} < (CW+1)'(TGT_ENTRIES));

  // RAM write and read control
  always_comb begin
    h_we    = 1'b0;
    t_we    = 1'b0;
    h_waddr = h_idx;
    t_waddr = t_idx;
    h_wdata = '{valid: 1'b1, tag: pc_r, cnt: cnt_new};
    t_wdata = '{valid: 1'b1, tag: pc_r, addr: act_tgt_r};
    rd_en   = (state_r == ST_INDEX) && h_done && t_done;
    if (state_r == ST_CLEAR) begin
      h_we    = clr_h;
      t_we    = clr_t;
      h_waddr = clr_cnt_r[HIW-1:0];
      t_waddr = clr_cnt_r[TIW-1:0];
      h_wdata = '0;
      t_wdata = '0;
    end else if (state_r == ST_WRITE && leave_wr) begin
      h_we = 1'b1;
      t_we = (func_r == FUNC_UPDATE) && act_taken_r;
    end
  end

  bbp_ram #(.WIDTH($bits(hist_ent_t)), .DEPTH(HIST_ENTRIES)) u_hist_ram (
    .clk     (clk),
    .wr_en   (h_we),
    .wr_addr (h_waddr),
    .wr_data (h_wdata),
    .rd_en   (rd_en),
    .rd_addr (h_idx),
    .rd_data (h_rdata)
  );

  bbp_ram #(.WIDTH($bits(tgt_ent_t)), .DEPTH(TGT_ENTRIES)) u_tgt_ram (
    .clk     (clk),
    .wr_en   (t_we),
    .wr_addr (t_waddr),
    .wr_data (t_wdata),
    .rd_en   (rd_en),
    .rd_addr (t_idx),
    .rd_data (t_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CW'(MAXD - 1)) begin
          state_nxt   = ST_IDLE;
          clr_cnt_nxt = '0;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == FUNC_CLEAR) begin
            state_nxt   = ST_CLEAR;
            clr_cnt_nxt = '0;
          end else if (idx_start) begin
            state_nxt = ST_INDEX;
          end
        end
      end
      ST_INDEX: begin
        if (h_done && t_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (leave_wr) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt   = ST_CLEAR;
        clr_cnt_nxt = '0;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_WRITE && func_r == FUNC_PREDICT && can_push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {7'b0, (pred_taken ? t_rdata.addr : dflt_r), pred_taken};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      func_r      <= in_tuser;
      pc_r        <= in_tdata[63:0];
      dflt_r      <= in_tdata[127:64];
      act_taken_r <= in_tdata[128];
      act_tgt_r   <= in_tdata[192:129];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
